FILE: design/bdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_pkg: shared types and constants for the button debounce click detector
// Event codes, result record, register indexes and reset defaults.
// ----------------------------------------------------------------------------
package bdc_pkg;

  // Default width of the elapsed-time counters.
  localparam int TIME_BITS_DEFAULT = 16;

  // Configuration port geometry.
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int TICKS_W     = 16;
  localparam int REPEAT_W    = 4;

  // Result queue depth; one tick can produce two results.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_LEVEL = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CLICK_GAP    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LONGER_PRESS = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_REPEATS  = 3'd6;

  // Register reset values.
  localparam logic [TICKS_W-1:0]  DEBOUNCE_RESET     = 16'd20;
  localparam logic [TICKS_W-1:0]  CLICK_GAP_RESET    = 16'd300;
  localparam logic [TICKS_W-1:0]  LONG_PRESS_RESET   = 16'd500;
  localparam logic [TICKS_W-1:0]  LONGER_PRESS_RESET = 16'd2000;
  localparam logic [REPEAT_W-1:0] MAX_REPEATS_RESET  = 4'd0;

  // Event codes carried on the result channel.
  typedef enum logic [2:0] {
    EV_CLICK        = 3'd0,
    EV_LONG_START   = 3'd1,
    EV_LONG_STOP    = 3'd2,
    EV_LONGER_START = 3'd3,
    EV_LONGER_STOP  = 3'd4
  } event_code_t;

  // One result item.
  typedef struct packed {
    event_code_t         code;
    logic [REPEAT_W-1:0] repeats;
    logic                last;
  } result_t;

  // Queue status seen by the front end.
  typedef struct packed {
    logic has_room;
    logic not_empty;
  } queue_status_t;

endpackage

FILE: design/bdc_result_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_result_queue: result queue for the click detector
// Takes up to two results per cycle and hands out one per transfer.
// ----------------------------------------------------------------------------
module bdc_result_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [1:0]             push_count,
  input  bdc_pkg::result_t       push_first,
  input  bdc_pkg::result_t       push_second,
  input  logic                   pop,
  output bdc_pkg::result_t       head,
  output bdc_pkg::queue_status_t status
);

  bdc_pkg::result_t                     mem [bdc_pkg::QUEUE_DEPTH];
  logic [bdc_pkg::QUEUE_PTR_W-1:0]      wr_ptr;
  logic [bdc_pkg::QUEUE_PTR_W-1:0]      rd_ptr;
  logic [bdc_pkg::QUEUE_CNT_W-1:0]      count;
  logic [bdc_pkg::QUEUE_PTR_W-1:0]      wr_ptr_second;

  assign wr_ptr_second = wr_ptr + bdc_pkg::QUEUE_PTR_W'(1);

  // Room for a full tick's worth of results.
  assign status.has_room  = (count <= bdc_pkg::QUEUE_CNT_W'(bdc_pkg::QUEUE_DEPTH - 2));
  assign status.not_empty = (count != '0);
  assign head             = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + bdc_pkg::QUEUE_PTR_W'(push_count);
      rd_ptr <= rd_ptr + bdc_pkg::QUEUE_PTR_W'(pop);
      count  <= count + bdc_pkg::QUEUE_CNT_W'(push_count) - bdc_pkg::QUEUE_CNT_W'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push_first;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr_second] <= push_second;
    end
  end

endmodule

FILE: design/button_debounce_click_detector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_click_detector_core: debounced button event detector
// Debounces a sampled pin and reports clicks, repeats and long presses.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transfer (in_valid/in_ready) is one millisecond tick carrying
//   the sampled pin. The tick is processed in the cycle it is taken, so one
//   tick per cycle is accepted. Each tick yields zero, one or two results on
//   the output channel (out_valid/out_ready); its results are queued in the
//   cycle the tick is taken, and last_event marks the final result of a tick.
//   Ending a longer press gives long stop followed by longer stop.
//   Results wait in a four-entry queue. in_ready stays high while the queue
//   has room for two results, so a stalled receiver holds off new ticks only
//   once three or more results are waiting; the rate is then set by how fast
//   the receiver drains the queue.
//   Registers are written through cfg_write/cfg_index/cfg_data at any edge;
//   they take effect on the next tick. Reset (rst, synchronous) restores the
//   register defaults, clears the debouncer and sequence state and empties
//   the queue. With enable low the time counters keep running but no state
//   changes and no results appear.
// ----------------------------------------------------------------------------
module button_debounce_click_detector_core #(
  parameter int TIME_BITS = bdc_pkg::TIME_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [bdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bdc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            pin_level,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      event_code,
  output logic [3:0]                      repeat_count,
  output logic                            last_event
);

  localparam int CMP_W = (TIME_BITS > bdc_pkg::TICKS_W) ? TIME_BITS : bdc_pkg::TICKS_W;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PRESSED  = 3'd1,
    PH_LONG     = 3'd2,
    PH_LONGER   = 3'd3,
    PH_RELEASED = 3'd4
  } phase_t;

  // Configuration registers.
  logic                            enable;
  logic                            invert_level;
  logic [bdc_pkg::TICKS_W-1:0]     debounce_ticks;
  logic [bdc_pkg::TICKS_W-1:0]     click_gap_ticks;
  logic [bdc_pkg::TICKS_W-1:0]     long_press_ticks;
  logic [bdc_pkg::TICKS_W-1:0]     longer_press_ticks;
  logic [bdc_pkg::REPEAT_W-1:0]    max_repeats;

  // Tick state.
  logic                            debounce_busy, debounce_busy_next;
  logic [TIME_BITS-1:0]            debounce_elapsed, debounce_elapsed_next;
  logic                            candidate_level, candidate_level_next;
  logic                            stable_level, stable_level_next;
  logic                            edge_pending, edge_pending_next;
  logic                            edge_press, edge_press_next;
  logic [TIME_BITS-1:0]            since_edge, since_edge_next;
  phase_t                          phase, phase_next;
  logic [bdc_pkg::REPEAT_W-1:0]    click_repeats, click_repeats_next;

  logic                            level;
  logic                            accept;
  logic [1:0]                      result_count;
  bdc_pkg::event_code_t            first_code, second_code;
  bdc_pkg::result_t                first_result, second_result;
  bdc_pkg::result_t                head;
  bdc_pkg::queue_status_t          queue_status;

  assign accept   = in_valid && in_ready;
  assign in_ready = queue_status.has_room;
  assign level    = pin_level ^ invert_level;

  // Configuration writes; unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable             <= 1'b0;
      invert_level       <= 1'b0;
      debounce_ticks     <= bdc_pkg::DEBOUNCE_RESET;
      click_gap_ticks    <= bdc_pkg::CLICK_GAP_RESET;
      long_press_ticks   <= bdc_pkg::LONG_PRESS_RESET;
      longer_press_ticks <= bdc_pkg::LONGER_PRESS_RESET;
      max_repeats        <= bdc_pkg::MAX_REPEATS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bdc_pkg::REG_ENABLE:       enable             <= cfg_data[0];
        bdc_pkg::REG_INVERT_LEVEL: invert_level       <= cfg_data[0];
        bdc_pkg::REG_DEBOUNCE:     debounce_ticks     <= cfg_data;
        bdc_pkg::REG_CLICK_GAP:    click_gap_ticks    <= cfg_data;
        bdc_pkg::REG_LONG_PRESS:   long_press_ticks   <= cfg_data;
        bdc_pkg::REG_LONGER_PRESS: longer_press_ticks <= cfg_data;
        bdc_pkg::REG_MAX_REPEATS:  max_repeats        <= cfg_data[bdc_pkg::REPEAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Debouncer followed by the press-sequence machine for one tick.
  always_comb begin
    since_edge_next       = (since_edge == '1) ? since_edge
                                               : since_edge + TIME_BITS'(1);
    debounce_elapsed_next = debounce_elapsed;
    if (debounce_busy && (debounce_elapsed != '1)) begin
      debounce_elapsed_next = debounce_elapsed + TIME_BITS'(1);
    end
    debounce_busy_next   = debounce_busy;
    candidate_level_next = candidate_level;
    stable_level_next    = stable_level;
    edge_pending_next    = edge_pending;
    edge_press_next      = edge_press;
    phase_next           = phase;
    click_repeats_next   = click_repeats;
    result_count         = 2'd0;
    first_code           = bdc_pkg::EV_CLICK;
    second_code          = bdc_pkg::EV_CLICK;

    if (enable) begin
      // Debouncer: a new level must hold for the debounce time.
      if (!debounce_busy) begin
        if (level != stable_level) begin
          debounce_busy_next    = 1'b1;
          debounce_elapsed_next = '0;
          candidate_level_next  = level;
        end
      end else if (level == candidate_level) begin
        if (CMP_W'(debounce_elapsed_next) >= CMP_W'(debounce_ticks)) begin
          stable_level_next  = candidate_level;
          since_edge_next    = '0;
          if (candidate_level != stable_level) begin
            edge_pending_next = 1'b1;
            edge_press_next   = candidate_level;
          end
          debounce_busy_next = 1'b0;
        end
      end else begin
        debounce_busy_next = 1'b0;
      end

      // Sequence machine sees the edge and timer left by the debouncer.
      unique case (phase)
        PH_IDLE: begin
          if (edge_pending_next && edge_press_next) begin
            edge_pending_next = 1'b0;
            phase_next        = PH_PRESSED;
          end
        end
        PH_PRESSED: begin
          if (edge_pending_next && !edge_press_next) begin
            edge_pending_next = 1'b0;
            phase_next        = PH_RELEASED;
          end else if (CMP_W'(since_edge_next) > CMP_W'(long_press_ticks)) begin
            result_count = 2'd1;
            first_code   = bdc_pkg::EV_LONG_START;
            phase_next   = PH_LONG;
          end
        end
        PH_LONG: begin
          if (edge_pending_next) begin
            result_count       = 2'd1;
            first_code         = bdc_pkg::EV_LONG_STOP;
            edge_pending_next  = 1'b0;
            phase_next         = PH_IDLE;
            click_repeats_next = '0;
          end else if (CMP_W'(since_edge_next) > CMP_W'(longer_press_ticks)) begin
            result_count = 2'd1;
            first_code   = bdc_pkg::EV_LONGER_START;
            phase_next   = PH_LONGER;
          end
        end
        PH_LONGER: begin
          if (edge_pending_next) begin
            result_count       = 2'd2;
            first_code         = bdc_pkg::EV_LONG_STOP;
            second_code        = bdc_pkg::EV_LONGER_STOP;
            edge_pending_next  = 1'b0;
            phase_next         = PH_IDLE;
            click_repeats_next = '0;
          end
        end
        PH_RELEASED: begin
          if (edge_pending_next && edge_press_next) begin
            edge_pending_next = 1'b0;
            if (click_repeats < max_repeats) begin
              phase_next         = PH_PRESSED;
              click_repeats_next = click_repeats + bdc_pkg::REPEAT_W'(1);
            end else begin
              result_count       = 2'd1;
              first_code         = bdc_pkg::EV_CLICK;
              phase_next         = PH_IDLE;
              click_repeats_next = '0;
            end
          end else if (CMP_W'(since_edge_next) > CMP_W'(click_gap_ticks)) begin
            result_count       = 2'd1;
            first_code         = bdc_pkg::EV_CLICK;
            phase_next         = PH_IDLE;
            click_repeats_next = '0;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Results carry the repeat count held when they fire.
  always_comb begin
    first_result.code     = first_code;
    first_result.repeats  = click_repeats;
    first_result.last     = (result_count == 2'd1);
    second_result.code    = second_code;
    second_result.repeats = click_repeats;
    second_result.last    = 1'b1;
  end

  // Tick state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_busy    <= 1'b0;
      debounce_elapsed <= '0;
      candidate_level  <= 1'b0;
      stable_level     <= 1'b0;
      edge_pending     <= 1'b0;
      edge_press       <= 1'b0;
      since_edge       <= '0;
      phase            <= PH_IDLE;
      click_repeats    <= '0;
    end else if (accept) begin
      debounce_busy    <= debounce_busy_next;
      debounce_elapsed <= debounce_elapsed_next;
      candidate_level  <= candidate_level_next;
      stable_level     <= stable_level_next;
      edge_pending     <= edge_pending_next;
      edge_press       <= edge_press_next;
      since_edge       <= since_edge_next;
      phase            <= phase_next;
      click_repeats    <= click_repeats_next;
    end
  end

  // Output queue.
  bdc_result_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_count  (accept ? result_count : 2'd0),
    .push_first  (first_result),
    .push_second (second_result),
    .pop         (out_valid && out_ready),
    .head        (head),
    .status      (queue_status)
  );

  assign out_valid    = queue_status.not_empty;
  assign event_code   = head.code;
  assign repeat_count = head.repeats;
  assign last_event   = head.last;

endmodule

FILE: design/bdc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_checker: port-level checks for the button debounce click detector
// Watches the result channel for stall stability, ordering, code range and reset behavior.
// ----------------------------------------------------------------------------
module bdc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] event_code,
  input logic [3:0] repeat_count,
  input logic       last_event
);

  // A held result keeps its payload until transferred.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_code)
      && $stable(repeat_count) && $stable(last_event))
    else $error("result changed while stalled");

  // Only the long stop of a longer press is followed by another result of its tick.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_event |-> event_code == bdc_pkg::EV_LONG_STOP)
    else $error("non-final result is not a long stop");

  // The longer stop is queued together with its long stop and follows at once.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_event |=>
      out_valid && last_event && event_code == bdc_pkg::EV_LONGER_STOP
      && $stable(repeat_count))
    else $error("longer stop missing after long stop");

  // Event codes stay in the defined range.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_code <= bdc_pkg::EV_LONGER_STOP)
    else $error("undefined event code");

  // The first cycle out of reset starts with an empty result queue.
  assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("result present after reset");

endmodule

bind button_debounce_click_detector_core bdc_checker u_bdc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .event_code   (event_code),
  .repeat_count (repeat_count),
  .last_event   (last_event)
);

FILE: verif/bdc_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_event_checker: result predictor and comparator for the click detector
// Watches the configuration port and both channels of the block. It runs its
// own model of the debouncer and the press-sequence machine on every tick
// transfer, queues the button events it predicts, and compares each result
// transfer with the oldest queued event, field by field.
// ----------------------------------------------------------------------------
module bdc_event_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [bdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bdc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            pin_level,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [2:0]                      event_code,
  input  logic [3:0]                      repeat_count,
  input  logic                            last_event,
  output int                              events_left,
  output int                              events_checked,
  output int                              mismatches
);

  localparam int TIME_W = bdc_pkg::TIME_BITS_DEFAULT;

  typedef enum logic [2:0] {
    SEQ_IDLE     = 3'd0,
    SEQ_PRESSED  = 3'd1,
    SEQ_LONG     = 3'd2,
    SEQ_LONGER   = 3'd3,
    SEQ_RELEASED = 3'd4
  } seq_phase_t;

  typedef enum logic [1:0] {
    EDGE_NONE    = 2'd0,
    EDGE_PRESS   = 2'd1,
    EDGE_RELEASE = 2'd2
  } edge_dir_t;

  // Shadow copy of the configuration registers.
  logic                         r_enable;
  logic                         r_invert;
  logic [bdc_pkg::TICKS_W-1:0]  r_debounce;
  logic [bdc_pkg::TICKS_W-1:0]  r_click_gap;
  logic [bdc_pkg::TICKS_W-1:0]  r_long;
  logic [bdc_pkg::TICKS_W-1:0]  r_longer;
  logic [bdc_pkg::REPEAT_W-1:0] r_max_repeats;

  // Model state of the debouncer and the sequence machine.
  logic                         db_busy;
  logic [TIME_W-1:0]            db_elapsed;
  logic                         candidate;
  logic                         stable;
  logic                         prev_stable;
  logic                         edge_pending;
  edge_dir_t                    edge_dir;
  logic [TIME_W-1:0]            since_edge;
  seq_phase_t                   phase;
  logic [bdc_pkg::REPEAT_W-1:0] repeats;

  bdc_pkg::result_t             predicted_events[$];
  bdc_pkg::result_t             want;

  function automatic logic [TIME_W-1:0] bump(input logic [TIME_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Advance the model by one tick and queue the events it fires.
  task automatic apply_tick(input logic raw);
    logic                         lvl;
    int                           n;
    bdc_pkg::event_code_t         ev[2];
    logic [bdc_pkg::REPEAT_W-1:0] rp[2];
    n = 0;
    since_edge = bump(since_edge);
    if (db_busy) db_elapsed = bump(db_elapsed);
    if (!r_enable) return;
    lvl = r_invert ? ~raw : raw;

    // Debouncer: a new level must hold for the debounce time.
    if (!db_busy) begin
      if (lvl != stable) begin
        db_busy    = 1'b1;
        db_elapsed = '0;
        candidate  = lvl;
      end
    end else if (lvl == candidate) begin
      if (db_elapsed >= r_debounce) begin
        prev_stable = stable;
        stable      = candidate;
        since_edge  = '0;
        if (stable != prev_stable) begin
          edge_pending = 1'b1;
          edge_dir     = stable ? EDGE_PRESS : EDGE_RELEASE;
        end
        db_busy = 1'b0;
      end
    end else begin
      // A glitch drops the candidate; the pin is looked at again next tick.
      db_busy = 1'b0;
    end

    // Press-sequence machine.
    case (phase)
      SEQ_IDLE: begin
        if (edge_pending && edge_dir == EDGE_PRESS) begin
          edge_pending = 1'b0;
          phase        = SEQ_PRESSED;
        end
      end
      SEQ_PRESSED: begin
        if (edge_pending && edge_dir == EDGE_RELEASE) begin
          edge_pending = 1'b0;
          phase        = SEQ_RELEASED;
        end else if (since_edge > r_long) begin
          ev[n] = bdc_pkg::EV_LONG_START;
          rp[n] = repeats;
          n++;
          phase = SEQ_LONG;
        end
      end
      SEQ_LONG: begin
        if (edge_pending) begin
          ev[n] = bdc_pkg::EV_LONG_STOP;
          rp[n] = repeats;
          n++;
          edge_pending = 1'b0;
          phase        = SEQ_IDLE;
          repeats      = '0;
        end else if (since_edge > r_longer) begin
          ev[n] = bdc_pkg::EV_LONGER_START;
          rp[n] = repeats;
          n++;
          phase = SEQ_LONGER;
        end
      end
      SEQ_LONGER: begin
        // Ending a longer press reports long stop, then longer stop.
        if (edge_pending) begin
          ev[0] = bdc_pkg::EV_LONG_STOP;
          rp[0] = repeats;
          ev[1] = bdc_pkg::EV_LONGER_STOP;
          rp[1] = repeats;
          n = 2;
          edge_pending = 1'b0;
          phase        = SEQ_IDLE;
          repeats      = '0;
        end
      end
      SEQ_RELEASED: begin
        if (edge_pending && edge_dir == EDGE_PRESS) begin
          edge_pending = 1'b0;
          if (repeats < r_max_repeats) begin
            phase   = SEQ_PRESSED;
            repeats = repeats + 1'b1;
          end else begin
            ev[n] = bdc_pkg::EV_CLICK;
            rp[n] = repeats;
            n++;
            phase   = SEQ_IDLE;
            repeats = '0;
          end
        end else if (since_edge > r_click_gap) begin
          ev[n] = bdc_pkg::EV_CLICK;
          rp[n] = repeats;
          n++;
          phase   = SEQ_IDLE;
          repeats = '0;
        end
      end
      default: begin
        phase = SEQ_IDLE;
      end
    endcase

    for (int i = 0; i < n; i++) begin
      predicted_events.push_back('{code: ev[i], repeats: rp[i], last: (i == n - 1)});
    end
  endtask

  initial begin
    events_checked = 0;
    mismatches     = 0;
    events_left    = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      r_enable      = 1'b0;
      r_invert      = 1'b0;
      r_debounce    = bdc_pkg::DEBOUNCE_RESET;
      r_click_gap   = bdc_pkg::CLICK_GAP_RESET;
      r_long        = bdc_pkg::LONG_PRESS_RESET;
      r_longer      = bdc_pkg::LONGER_PRESS_RESET;
      r_max_repeats = bdc_pkg::MAX_REPEATS_RESET;
      db_busy       = 1'b0;
      db_elapsed    = '0;
      candidate     = 1'b0;
      stable        = 1'b0;
      prev_stable   = 1'b0;
      edge_pending  = 1'b0;
      edge_dir      = EDGE_NONE;
      since_edge    = '0;
      phase         = SEQ_IDLE;
      repeats       = '0;
      predicted_events.delete();
    end else begin
      // Result transfer: compare with the oldest predicted event.
      if (out_valid && out_ready) begin
        if (predicted_events.size() == 0) begin
          $error("result transfer with no event expected: code %0d repeats %0d last %0d",
                 event_code, repeat_count, last_event);
          mismatches++;
        end else begin
          want = predicted_events.pop_front();
          events_checked++;
          if (event_code !== want.code) begin
            $error("event_code: expected %0d, got %0d", want.code, event_code);
            mismatches++;
          end
          if (repeat_count !== want.repeats) begin
            $error("repeat_count: expected %0d, got %0d", want.repeats, repeat_count);
            mismatches++;
          end
          if (last_event !== want.last) begin
            $error("last_event: expected %0d, got %0d", want.last, last_event);
            mismatches++;
          end
        end
      end

      // Tick transfer runs with the registers as they were before this edge.
      if (in_valid && in_ready) apply_tick(pin_level);

      if (cfg_write) begin
        case (cfg_index)
          bdc_pkg::REG_ENABLE:       r_enable      = cfg_data[0];
          bdc_pkg::REG_INVERT_LEVEL: r_invert      = cfg_data[0];
          bdc_pkg::REG_DEBOUNCE:     r_debounce    = cfg_data[bdc_pkg::TICKS_W-1:0];
          bdc_pkg::REG_CLICK_GAP:    r_click_gap   = cfg_data[bdc_pkg::TICKS_W-1:0];
          bdc_pkg::REG_LONG_PRESS:   r_long        = cfg_data[bdc_pkg::TICKS_W-1:0];
          bdc_pkg::REG_LONGER_PRESS: r_longer      = cfg_data[bdc_pkg::TICKS_W-1:0];
          bdc_pkg::REG_MAX_REPEATS:  r_max_repeats = cfg_data[bdc_pkg::REPEAT_W-1:0];
          default: ;
        endcase
      end
    end
    events_left <= predicted_events.size();
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the button debounce click detector
// Drives pin ticks shaped as button gestures (taps, multi-clicks, long and
// longer holds, contact chatter) plus random noise under a series of register
// settings and handshake pressures. The event checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [bdc_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam int NUM_SETTINGS = 10;
  localparam int DIRECTED_LEN = 25;
  // Tap with one repeat, long press into longer press, then a glitch.
  localparam logic [0:DIRECTED_LEN-1] DIRECTED_PINS = 25'b1100110000001111111100100;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [bdc_pkg::CFG_INDEX_W-1:0] cfg_index = bdc_pkg::REG_ENABLE;
  logic [bdc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            pin_level = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [2:0]                      event_code;
  logic [3:0]                      repeat_count;
  logic                            last_event;

  int events_left;
  int events_checked;
  int mismatches;

  // Current settings, kept here to shape the gestures.
  logic                         cfg_invert;
  logic [bdc_pkg::TICKS_W-1:0]  cfg_debounce;
  logic [bdc_pkg::TICKS_W-1:0]  cfg_gap;
  logic [bdc_pkg::TICKS_W-1:0]  cfg_long;
  logic [bdc_pkg::TICKS_W-1:0]  cfg_longer;
  logic [bdc_pkg::REPEAT_W-1:0] cfg_repeats;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int phase_ticks;
  int budget;
  int total_ticks = 0;
  int settings_used = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  button_debounce_click_detector_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pin_level    (pin_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_code   (event_code),
    .repeat_count (repeat_count),
    .last_event   (last_event)
  );

  bdc_event_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pin_level      (pin_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_code     (event_code),
    .repeat_count   (repeat_count),
    .last_event     (last_event),
    .events_left    (events_left),
    .events_checked (events_checked),
    .mismatches     (mismatches)
  );

  // Receiver stalls at random according to the current pressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // One tick transfer, with an optional idle gap in front of it.
  task automatic sample_pin(input logic lvl);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid  <= 1'b1;
    pin_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    phase_ticks++;
    total_ticks++;
  endtask

  // Hold a level, sometimes after a few ticks of contact chatter.
  task automatic hold_level(input logic lvl, input int len);
    int chatter;
    chatter = ($urandom_range(9) < 3) ? $urandom_range(3, 1) : 0;
    for (int i = 0; i < chatter; i++) sample_pin(lvl ^ i[0]);
    for (int i = 0; i < len; i++) sample_pin(lvl);
  endtask

  task automatic pin_noise();
    int n;
    n = $urandom_range(8, 1);
    for (int i = 0; i < n; i++) sample_pin(1'($urandom_range(1)));
  endtask

  // A run of presses: mostly taps, some long or longer holds, with gaps that
  // either chain repeats or let the click report.
  task automatic press_gesture();
    int   clicks;
    int   hold;
    int   pick;
    logic active;
    active = ~cfg_invert;
    clicks = $urandom_range(cfg_repeats + 2, 1);
    for (int k = 0; k < clicks && phase_ticks < budget; k++) begin
      pick = $urandom_range(9);
      if (pick < 7) hold = cfg_debounce + 2 + $urandom_range(3);
      else if (pick < 9) hold = cfg_debounce + cfg_long + $urandom_range(4);
      else hold = cfg_debounce + cfg_longer + $urandom_range(5);
      hold_level(active, hold);
      if (k == clicks - 1) hold = cfg_debounce + cfg_gap + 2 + $urandom_range(3);
      else hold = cfg_debounce + 2 + $urandom_range(cfg_gap);
      hold_level(~active, hold);
    end
  endtask

  // Stop sending and wait until every predicted event has been taken.
  task automatic drain_events();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (events_left != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bdc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [bdc_pkg::CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_registers(input logic en, input logic inv,
                                   input logic [bdc_pkg::TICKS_W-1:0] db,
                                   input logic [bdc_pkg::TICKS_W-1:0] gap,
                                   input logic [bdc_pkg::TICKS_W-1:0] lng,
                                   input logic [bdc_pkg::TICKS_W-1:0] lngr,
                                   input logic [bdc_pkg::REPEAT_W-1:0] rep);
    cfg_invert   = inv;
    cfg_debounce = db;
    cfg_gap      = gap;
    cfg_long     = lng;
    cfg_longer   = lngr;
    cfg_repeats  = rep;
    write_reg(bdc_pkg::REG_ENABLE, {{(bdc_pkg::CFG_DATA_W-1){1'b0}}, en});
    write_reg(bdc_pkg::REG_INVERT_LEVEL, {{(bdc_pkg::CFG_DATA_W-1){1'b0}}, inv});
    write_reg(bdc_pkg::REG_DEBOUNCE, db);
    write_reg(bdc_pkg::REG_CLICK_GAP, gap);
    write_reg(bdc_pkg::REG_LONG_PRESS, lng);
    write_reg(bdc_pkg::REG_LONGER_PRESS, lngr);
    write_reg(bdc_pkg::REG_MAX_REPEATS,
              {{(bdc_pkg::CFG_DATA_W-bdc_pkg::REPEAT_W){1'b0}}, rep});
    // An index past the register list must change nothing.
    write_reg(REG_UNUSED, bdc_pkg::CFG_DATA_W'($urandom_range(16'hFFFF)));
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with small thresholds and no handshake pressure.
    program_registers(1'b1, 1'b0, 16'd0, 16'd3, 16'd2, 16'd4, 4'd1);
    for (int i = 0; i < DIRECTED_LEN; i++) sample_pin(DIRECTED_PINS[i]);

    // Random part: one register setting and one pressure mode per phase.
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      drain_events();
      case (p)
        0: program_registers(1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 4'd0);
        1: program_registers(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
        2: program_registers(1'b0, 1'b0, 16'd2, 16'd6, 16'd10, 16'd20, 4'd2);
        3: program_registers(1'b1, 1'b0, 16'd1, 16'd12, 16'd20, 16'd40, 4'hF);
        default: begin
          program_registers(1'b1, 1'($urandom_range(1)),
                            bdc_pkg::TICKS_W'($urandom_range(4)),
                            bdc_pkg::TICKS_W'($urandom_range(12)),
                            bdc_pkg::TICKS_W'($urandom_range(24)),
                            bdc_pkg::TICKS_W'($urandom_range(48)),
                            bdc_pkg::REPEAT_W'($urandom_range(15)));
        end
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      budget = (p == 1 || p == 2) ? 40 : 210;
      phase_ticks = 0;
      while (phase_ticks < budget) begin
        if (p == 1 || $urandom_range(99) < 15) pin_noise();
        else press_gesture();
      end
    end
    drain_events();

    if (events_left != 0) begin
      $error("%0d predicted events never arrived", events_left);
    end
    $display("Run covered %0d ticks under %0d register settings; %0d events checked.",
             total_ticks, settings_used, events_checked);
    $display("Gestures included taps, repeats, long and longer holds, chatter and noise.");
    if (mismatches == 0 && events_left == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/bdc_pkg.sv
design/bdc_result_queue.sv
design/button_debounce_click_detector_core.sv
design/bdc_checker.sv
verif/bdc_event_checker.sv
verif/tb_top.sv
